// ===== design/jmsc_pkg.sv =====
// Shared types and constants for the joint motion safety check.
// Holds field widths, register and violation codes, and the beat structs.
// No dependencies; every other design file imports this package.
package jmsc_pkg;

  // Frame length and index width
  localparam int JOINTS = 12;
  localparam int JIDX_W = 4;

  // Field widths
  localparam int ANGLE_W    = 16;
  localparam int SPEED_W    = 16;
  localparam int CHANGE_W   = 16;
  localparam int RATE_HZ_W  = 10;
  localparam int RATE_W     = 22;
  localparam int SUM_W      = 20;
  localparam int PROD_W     = CHANGE_W + RATE_HZ_W;
  localparam int RATE_SHIFT = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;

  // Queue between front and back, and result queue depth (power of two)
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHECK_ENABLE,
    REG_ENFORCE_MASK,
    REG_POLICY_RATE,
    REG_TARGET_RATE_LIMIT,
    REG_SPEED_LIMIT,
    REG_SIG_CHANGE,
    REG_AGG_LIMIT
  } cfg_reg_t;

  typedef enum logic [1:0] {
    VIOL_NONE,
    VIOL_TARGET_RATE,
    VIOL_AGGREGATE,
    VIOL_FEEDBACK
  } viol_t;

  // Enforce mask bits
  localparam int MASK_RATE  = 0;
  localparam int MASK_AGG   = 1;
  localparam int MASK_SPEED = 2;

  typedef struct packed {
    logic                 check_enable;
    logic [2:0]           enforce_mask;
    logic [RATE_HZ_W-1:0] policy_rate_hz;
    logic [RATE_W-1:0]    target_rate_limit;
    logic [SPEED_W-1:0]   feedback_speed_limit;
    logic [CHANGE_W-1:0]  significant_change;
    logic [SUM_W-1:0]     aggregate_change_limit;
  } cfg_t;

  // Classified sample passed from front to back
  typedef struct packed {
    logic [CHANGE_W-1:0] change;
    logic [SPEED_W-1:0]  speed;
    logic                big;
  } sample_t;

  typedef struct packed {
    viol_t               violation;
    logic [JIDX_W-1:0]   detail;
    logic [RATE_W-1:0]   peak_target_rate;
    logic [SPEED_W-1:0]  peak_feedback_speed;
    logic [SUM_W-1:0]    total_change;
    logic [JIDX_W-1:0]   big_change_count;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== design/jmsc_front.sv =====
// Front end: accepts joint samples and classifies them.
// Forms absolute change, absolute speed and the significance flag.
// Depends on jmsc_pkg.
module jmsc_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic signed [jmsc_pkg::ANGLE_W-1:0] new_target,
  input  logic signed [jmsc_pkg::ANGLE_W-1:0] old_target,
  input  logic signed [jmsc_pkg::SPEED_W-1:0] joint_speed,
  input  logic [jmsc_pkg::CHANGE_W-1:0]  significant_change,
  input  jmsc_pkg::q_status_t            qst,
  output logic                           q_push,
  output jmsc_pkg::sample_t              q_data
);
  import jmsc_pkg::*;

  logic                  f_valid;
  sample_t               f_sample;
  logic                  accept;
  logic signed [ANGLE_W:0] diff;
  logic signed [SPEED_W:0] spd;
  sample_t               classified;

  // Absolute change, absolute speed, significance
  always_comb begin
    diff = {new_target[ANGLE_W-1], new_target} - {old_target[ANGLE_W-1], old_target};
    spd  = {joint_speed[SPEED_W-1], joint_speed};
    classified.change = diff[ANGLE_W] ? CHANGE_W'(-diff) : CHANGE_W'(diff);
    classified.speed  = spd[SPEED_W] ? SPEED_W'(-spd) : SPEED_W'(spd);
    classified.big    = classified.change > significant_change;
  end

  assign full   = f_valid & qst.full;
  assign accept = push & ~full;
  assign q_push = f_valid & ~qst.full;
  assign q_data = f_sample;

  // Hold the classified beat until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= accept | (f_valid & qst.full);
    end
    if (accept) begin
      f_sample <= classified;
    end
  end

endmodule

// ===== design/jmsc_queue.sv =====
// Short queue of classified samples between front and back.
// Lets either side stall without stopping the other.
// Depends on jmsc_pkg.
module jmsc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  jmsc_pkg::sample_t push_data,
  input  logic              pop,
  output jmsc_pkg::sample_t head,
  output jmsc_pkg::q_status_t qst
);
  import jmsc_pkg::*;

  sample_t           mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign qst.full  = count == QCNT_W'(QDEPTH);
  assign qst.empty = count == '0;
  assign do_push   = push & ~qst.full;
  assign do_pop    = pop & ~qst.empty;
  assign head      = mem[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

  // Store beats
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("sample queue count above depth");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + 1'b1)
    else $error("sample queue count missed a push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == QCNT_W'(QDEPTH)) |-> wr_ptr == rd_ptr)
    else $error("sample queue pointers disagree with count");

endmodule

// ===== design/jmsc_back.sv =====
// Back end: rate multiply, frame accumulation, violation pick, result queue.
// Pops classified samples and emits one result per frame of JOINTS samples.
// Depends on jmsc_pkg.
module jmsc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  jmsc_pkg::cfg_t       cfg,
  input  jmsc_pkg::sample_t    head,
  input  jmsc_pkg::q_status_t  qst,
  output logic                 q_pop,
  input  logic                 pop,
  output logic                 empty,
  output jmsc_pkg::result_t    res
);
  import jmsc_pkg::*;

  // Multiply stage
  logic                s_valid;
  logic [RATE_W-1:0]   s_rate;
  logic [CHANGE_W-1:0] s_change;
  logic [SPEED_W-1:0]  s_speed;
  logic                s_big;
  logic [PROD_W-1:0]   prod;
  logic                adv;

  // Frame state
  logic [JIDX_W-1:0]  joint_counter;
  logic [SUM_W-1:0]   change_sum;
  logic [JIDX_W-1:0]  change_count;
  logic [RATE_W-1:0]  rate_peak;
  logic [JIDX_W-1:0]  rate_peak_joint;
  logic [SPEED_W-1:0] speed_peak;
  logic [JIDX_W-1:0]  speed_peak_joint;

  logic [SUM_W-1:0]   change_sum_next;
  logic [JIDX_W-1:0]  change_count_next;
  logic [RATE_W-1:0]  rate_peak_next;
  logic [JIDX_W-1:0]  rate_peak_joint_next;
  logic [SPEED_W-1:0] speed_peak_next;
  logic [JIDX_W-1:0]  speed_peak_joint_next;
  logic               last;
  result_t            res_next;

  // Result queue
  result_t           oq_mem [QDEPTH];
  logic [QPTR_W-1:0] oq_wr;
  logic [QPTR_W-1:0] oq_rd;
  logic [QCNT_W-1:0] oq_count;
  logic              oq_push;
  logic              oq_pop;

  assign adv   = s_valid & (oq_count != QCNT_W'(QDEPTH));
  assign q_pop = ~qst.empty & (~s_valid | adv);
  assign prod  = PROD_W'(head.change) * PROD_W'(cfg.policy_rate_hz);

  // Load the multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (~s_valid | adv) begin
      s_valid <= q_pop;
    end
    if (q_pop) begin
      s_rate   <= prod[PROD_W-1:RATE_SHIFT];
      s_change <= head.change;
      s_speed  <= head.speed;
      s_big    <= head.big;
    end
  end

  // Fold one sample into the frame totals
  always_comb begin
    change_sum_next       = change_sum + SUM_W'(s_change);
    change_count_next     = change_count + JIDX_W'(s_big);
    rate_peak_next        = rate_peak;
    rate_peak_joint_next  = rate_peak_joint;
    speed_peak_next       = speed_peak;
    speed_peak_joint_next = speed_peak_joint;
    if (s_rate > rate_peak) begin
      rate_peak_next       = s_rate;
      rate_peak_joint_next = joint_counter;
    end
    if (s_speed > speed_peak) begin
      speed_peak_next       = s_speed;
      speed_peak_joint_next = joint_counter;
    end
    last = ({1'b0, joint_counter} + 1'b1) >= (JIDX_W+1)'(JOINTS);
  end

  // Pick the first enforced violation by priority
  always_comb begin
    res_next = '0;
    if (cfg.check_enable) begin
      res_next.peak_target_rate    = rate_peak_next;
      res_next.peak_feedback_speed = speed_peak_next;
      res_next.total_change        = change_sum_next;
      res_next.big_change_count    = change_count_next;
      if (cfg.enforce_mask[MASK_RATE] && rate_peak_next > cfg.target_rate_limit) begin
        res_next.violation = VIOL_TARGET_RATE;
        res_next.detail    = rate_peak_joint_next;
      end else if (cfg.enforce_mask[MASK_AGG] &&
                   change_sum_next > cfg.aggregate_change_limit) begin
        res_next.violation = VIOL_AGGREGATE;
        res_next.detail    = change_count_next;
      end else if (cfg.enforce_mask[MASK_SPEED] &&
                   speed_peak_next > cfg.feedback_speed_limit) begin
        res_next.violation = VIOL_FEEDBACK;
        res_next.detail    = speed_peak_joint_next;
      end
    end
  end

  assign oq_push = adv & last;

  // Update frame state; clear it after the last joint
  always_ff @(posedge clk) begin
    if (rst || oq_push) begin
      joint_counter    <= '0;
      change_sum       <= '0;
      change_count     <= '0;
      rate_peak        <= '0;
      rate_peak_joint  <= '0;
      speed_peak       <= '0;
      speed_peak_joint <= '0;
    end else if (adv) begin
      joint_counter    <= joint_counter + 1'b1;
      change_sum       <= change_sum_next;
      change_count     <= change_count_next;
      rate_peak        <= rate_peak_next;
      rate_peak_joint  <= rate_peak_joint_next;
      speed_peak       <= speed_peak_next;
      speed_peak_joint <= speed_peak_joint_next;
    end
  end

  // Result queue
  assign empty  = oq_count == '0;
  assign oq_pop = pop & ~empty;
  assign res    = oq_mem[oq_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= '0;
      oq_rd    <= '0;
      oq_count <= '0;
    end else begin
      if (oq_push) oq_wr <= oq_wr + 1'b1;
      if (oq_pop)  oq_rd <= oq_rd + 1'b1;
      oq_count <= oq_count + QCNT_W'(oq_push) - QCNT_W'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_mem[oq_wr] <= res_next;
    end
  end

  a_counter_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, joint_counter} < (JIDX_W+1)'(JOINTS))
    else $error("joint counter ran past the frame");

  a_oq_bound: assert property (@(posedge clk) disable iff (rst)
    oq_count <= QCNT_W'(QDEPTH))
    else $error("result queue count above depth");

  a_oq_drain: assert property (@(posedge clk) disable iff (rst)
    (oq_pop && !oq_push) |=> oq_count == $past(oq_count) - 1'b1)
    else $error("result queue count missed a pop");

  a_disabled_zero: assert property (@(posedge clk) disable iff (rst)
    (oq_push && !cfg.check_enable) |-> res_next == '0)
    else $error("disabled frame produced a nonzero result");

endmodule

// ===== design/joint_motion_safety_check_top.sv =====
// Result path: front register, sample queue, multiply stage, then the result queue.
// Throughput: one sample per cycle sustained; the back end's single multiply stage and
// the two-entry queues set it, and a full result queue stalls the back end.
// Reset: rst is synchronous, active high; it clears all queues and the frame state
// and returns the configuration registers to their documented defaults.
// Top level of the joint motion safety check; depends on jmsc_pkg, jmsc_front,
// jmsc_queue and jmsc_back.
module joint_motion_safety_check_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // Sample input
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [jmsc_pkg::ANGLE_W-1:0]  new_target,
  input  logic signed [jmsc_pkg::ANGLE_W-1:0]  old_target,
  input  logic signed [jmsc_pkg::SPEED_W-1:0]  joint_speed,
  // Result output
  output logic                                 empty,
  input  logic                                 pop,
  output logic [1:0]                           violation,
  output logic [jmsc_pkg::JIDX_W-1:0]          detail,
  output logic [jmsc_pkg::RATE_W-1:0]          peak_target_rate,
  output logic [jmsc_pkg::SPEED_W-1:0]         peak_feedback_speed,
  output logic [jmsc_pkg::SUM_W-1:0]           total_change,
  output logic [jmsc_pkg::JIDX_W-1:0]          big_change_count,
  // Configuration write port
  input  logic                                 cfg_wr_en,
  input  logic [jmsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [jmsc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import jmsc_pkg::*;

  cfg_t      cfg;
  q_status_t qst;
  logic      q_push;
  logic      q_pop;
  sample_t   q_in;
  sample_t   q_head;
  result_t   res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.check_enable           <= 1'b0;
      cfg.enforce_mask           <= 3'd7;
      cfg.policy_rate_hz         <= RATE_HZ_W'(50);
      cfg.target_rate_limit      <= RATE_W'(2560);
      cfg.feedback_speed_limit   <= SPEED_W'(5120);
      cfg.significant_change     <= CHANGE_W'(410);
      cfg.aggregate_change_limit <= SUM_W'(8192);
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_CHECK_ENABLE:      cfg.check_enable           <= cfg_data[0];
        REG_ENFORCE_MASK:      cfg.enforce_mask           <= cfg_data[2:0];
        REG_POLICY_RATE:       cfg.policy_rate_hz         <= cfg_data[RATE_HZ_W-1:0];
        REG_TARGET_RATE_LIMIT: cfg.target_rate_limit      <= cfg_data[RATE_W-1:0];
        REG_SPEED_LIMIT:       cfg.feedback_speed_limit   <= cfg_data[SPEED_W-1:0];
        REG_SIG_CHANGE:        cfg.significant_change     <= cfg_data[CHANGE_W-1:0];
        REG_AGG_LIMIT:         cfg.aggregate_change_limit <= cfg_data[SUM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  jmsc_front u_front (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .new_target         (new_target),
    .old_target         (old_target),
    .joint_speed        (joint_speed),
    .significant_change (cfg.significant_change),
    .qst                (qst),
    .q_push             (q_push),
    .q_data             (q_in)
  );

  jmsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .qst       (qst)
  );

  jmsc_back u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .head  (q_head),
    .qst   (qst),
    .q_pop (q_pop),
    .pop   (pop),
    .empty (empty),
    .res   (res)
  );

  // Drive result ports from the queue head
  assign violation           = res.violation;
  assign detail              = res.detail;
  assign peak_target_rate    = res.peak_target_rate;
  assign peak_feedback_speed = res.peak_feedback_speed;
  assign total_change        = res.total_change;
  assign big_change_count    = res.big_change_count;

endmodule

// ===== test/joint_motion_safety_check_top_tb.sv =====
// Self-checking bench for joint_motion_safety_check_top: drives sample beats, pops verdicts.
// A per-sample predictor of the frame accumulators sets the expected verdict per frame.
// Depends on jmsc_pkg and the design top level only.
module joint_motion_safety_check_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jmsc_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_WAIT  = 10;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 8;
  localparam int FRAMES_EACH  = 12;
  localparam int DIRECTED_LEN = 24;

  typedef struct {
    logic signed [ANGLE_W-1:0] new_target;
    logic signed [ANGLE_W-1:0] old_target;
    logic signed [SPEED_W-1:0] joint_speed;
    bit                        enable_first;
    bit                        typed;
    result_t                   want;
  } stim_row_t;

  logic                      clk;
  logic                      rst;
  logic                      push;
  logic                      full;
  logic signed [ANGLE_W-1:0] new_target;
  logic signed [ANGLE_W-1:0] old_target;
  logic signed [SPEED_W-1:0] joint_speed;
  logic                      empty;
  logic                      pop;
  logic [1:0]                violation;
  logic [JIDX_W-1:0]         detail;
  logic [RATE_W-1:0]         peak_target_rate;
  logic [SPEED_W-1:0]        peak_feedback_speed;
  logic [SUM_W-1:0]          total_change;
  logic [JIDX_W-1:0]         big_change_count;
  logic                      cfg_wr_en;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;

  // Verdicts owed by the block, oldest first
  result_t frame_verdicts[$];
  int      mismatches;
  int      cycle_count;
  int      source_gap_pct;
  int      sink_stall_pct;
  bit      hold_request;

  // Predictor copy of the registers and of the frame accumulators
  cfg_t                live_cfg;
  logic [JIDX_W-1:0]   acc_joint;
  logic [SUM_W-1:0]    acc_sum;
  logic [JIDX_W-1:0]   acc_big;
  logic [RATE_W-1:0]   acc_rate_peak;
  logic [JIDX_W-1:0]   acc_rate_joint;
  logic [SPEED_W-1:0]  acc_speed_peak;
  logic [JIDX_W-1:0]   acc_speed_joint;

  stim_row_t directed_rows[DIRECTED_LEN];

  joint_motion_safety_check_top u_top (
    .clk                 (clk),
    .rst                 (rst),
    .push                (push),
    .full                (full),
    .new_target          (new_target),
    .old_target          (old_target),
    .joint_speed         (joint_speed),
    .empty               (empty),
    .pop                 (pop),
    .violation           (violation),
    .detail              (detail),
    .peak_target_rate    (peak_target_rate),
    .peak_feedback_speed (peak_feedback_speed),
    .total_change        (total_change),
    .big_change_count    (big_change_count),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
  endtask

  // Clear the frame accumulators
  task automatic clear_frame();
    acc_joint       = '0;
    acc_sum         = '0;
    acc_big         = '0;
    acc_rate_peak   = '0;
    acc_rate_joint  = '0;
    acc_speed_peak  = '0;
    acc_speed_joint = '0;
  endtask

  // Fold one joint sample into the frame; after the last joint, form the verdict
  task automatic accumulate_joint(input logic signed [ANGLE_W-1:0] nt,
                                  input logic signed [ANGLE_W-1:0] ot,
                                  input logic signed [SPEED_W-1:0] sp,
                                  output bit done, output result_t verdict);
    int          diff;
    int          spd;
    int unsigned delta;
    int unsigned speed;
    int unsigned rate;
    logic [JIDX_W-1:0] idx;
    diff    = int'(nt) - int'(ot);
    spd     = int'(sp);
    delta   = (diff < 0) ? -diff : diff;
    speed   = (spd < 0) ? -spd : spd;
    rate    = (delta * int'(live_cfg.policy_rate_hz)) >> RATE_SHIFT;
    idx     = acc_joint;
    done    = 1'b0;
    verdict = '0;

    acc_sum = SUM_W'(acc_sum + delta);
    if (delta > int'(live_cfg.significant_change))
      acc_big = JIDX_W'(acc_big + 1);
    // Strictly larger replaces, so ties keep the first joint
    if (rate > int'(acc_rate_peak)) begin
      acc_rate_peak  = RATE_W'(rate);
      acc_rate_joint = idx;
    end
    if (speed > int'(acc_speed_peak)) begin
      acc_speed_peak  = SPEED_W'(speed);
      acc_speed_joint = idx;
    end

    if (int'(idx) + 1 < JOINTS) begin
      acc_joint = JIDX_W'(idx + 1);
    end else begin
      done = 1'b1;
      if (live_cfg.check_enable) begin
        verdict.violation = VIOL_NONE;
        verdict.detail    = '0;
        if (live_cfg.enforce_mask[MASK_RATE] &&
            acc_rate_peak > live_cfg.target_rate_limit) begin
          verdict.violation = VIOL_TARGET_RATE;
          verdict.detail    = acc_rate_joint;
        end else if (live_cfg.enforce_mask[MASK_AGG] &&
                     acc_sum > live_cfg.aggregate_change_limit) begin
          verdict.violation = VIOL_AGGREGATE;
          verdict.detail    = acc_big;
        end else if (live_cfg.enforce_mask[MASK_SPEED] &&
                     acc_speed_peak > live_cfg.feedback_speed_limit) begin
          verdict.violation = VIOL_FEEDBACK;
          verdict.detail    = acc_speed_joint;
        end
        verdict.peak_target_rate    = acc_rate_peak;
        verdict.peak_feedback_speed = acc_speed_peak;
        verdict.total_change        = acc_sum;
        verdict.big_change_count    = acc_big;
      end
      clear_frame();
    end
  endtask

  // Offer one sample beat, hold it until accepted, then predict
  task automatic send_sample(input logic signed [ANGLE_W-1:0] nt,
                             input logic signed [ANGLE_W-1:0] ot,
                             input logic signed [SPEED_W-1:0] sp,
                             input bit use_typed, input result_t typed);
    bit      done;
    result_t verdict;
    while ($urandom_range(0, 99) < source_gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push        <= 1'b1;
    new_target  <= nt;
    old_target  <= ot;
    joint_speed <= sp;
    @(posedge clk);
    while (full) @(posedge clk);
    accumulate_joint(nt, ot, sp, done, verdict);
    if (done) frame_verdicts.push_back(use_typed ? typed : verdict);
  endtask

  // Drain every owed verdict, then let the pipeline run empty
  task automatic settle_block();
    push <= 1'b0;
    while (frame_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // Write all registers back to back, one per cycle
  task automatic apply_settings(input cfg_t s);
    cfg_reg_t r;
    for (int i = 0; i <= int'(REG_AGG_LIMIT); i++) begin
      r = cfg_reg_t'(i);
      cfg_wr_en <= 1'b1;
      cfg_index <= r;
      case (r)
        REG_CHECK_ENABLE:      cfg_data <= CFG_DATA_W'(s.check_enable);
        REG_ENFORCE_MASK:      cfg_data <= CFG_DATA_W'(s.enforce_mask);
        REG_POLICY_RATE:       cfg_data <= CFG_DATA_W'(s.policy_rate_hz);
        REG_TARGET_RATE_LIMIT: cfg_data <= CFG_DATA_W'(s.target_rate_limit);
        REG_SPEED_LIMIT:       cfg_data <= CFG_DATA_W'(s.feedback_speed_limit);
        REG_SIG_CHANGE:        cfg_data <= CFG_DATA_W'(s.significant_change);
        default:               cfg_data <= CFG_DATA_W'(s.aggregate_change_limit);
      endcase
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    live_cfg = s;
  endtask

  // Roughly log-uniform value below 2**w
  function automatic int unsigned span_rand(input int w);
    int unsigned mask;
    mask = (32'd1 << $urandom_range(0, w)) - 1;
    return $urandom & mask;
  endfunction

  function automatic stim_row_t sample_row(input int nt, input int ot, input int sp);
    stim_row_t r;
    r.new_target   = ANGLE_W'(nt);
    r.old_target   = ANGLE_W'(ot);
    r.joint_speed  = SPEED_W'(sp);
    r.enable_first = 1'b0;
    r.typed        = 1'b0;
    r.want         = '0;
    return r;
  endfunction

  // Result side: check each popped beat, stall at random or for a long hold
  initial begin
    result_t want;
    int      hold_left;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (frame_verdicts.size() == 0) begin
          report_mismatch("result beat with no frame pending");
        end else begin
          want = frame_verdicts.pop_front();
          check_field("violation", 32'(violation), 32'(want.violation));
          check_field("detail", 32'(detail), 32'(want.detail));
          check_field("peak_target_rate", 32'(peak_target_rate),
                      32'(want.peak_target_rate));
          check_field("peak_feedback_speed", 32'(peak_feedback_speed),
                      32'(want.peak_feedback_speed));
          check_field("total_change", 32'(total_change), 32'(want.total_change));
          check_field("big_change_count", 32'(big_change_count),
                      32'(want.big_change_count));
        end
      end
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("joint_motion_safety_check_top_tb: done, errors");
    $finish;
  end

  // Stimulus
  initial begin
    cfg_t s;
    int   style;
    logic signed [ANGLE_W-1:0] nt;
    logic signed [ANGLE_W-1:0] ot;
    logic signed [SPEED_W-1:0] sp;

    rst            = 1'b1;
    push           = 1'b0;
    new_target     = '0;
    old_target     = '0;
    joint_speed    = '0;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    mismatches     = 0;
    source_gap_pct = 0;
    sink_stall_pct = 0;
    hold_request   = 1'b0;

    live_cfg.check_enable           = 1'b0;
    live_cfg.enforce_mask           = 3'd7;
    live_cfg.policy_rate_hz         = 10'd50;
    live_cfg.target_rate_limit      = 22'd2560;
    live_cfg.feedback_speed_limit   = 16'd5120;
    live_cfg.significant_change     = 16'd410;
    live_cfg.aggregate_change_limit = 20'd8192;
    clear_frame();

    // Frame under reset settings: disabled, so extremes give an all-zero verdict
    directed_rows[0]  = sample_row(32767, -32768, -32768);
    directed_rows[1]  = sample_row(-32768, 32767, 32767);
    directed_rows[2]  = sample_row(0, 0, 0);
    directed_rows[3]  = sample_row(-1, 0, -1);
    directed_rows[4]  = sample_row(21845, -21846, -21846);
    directed_rows[5]  = sample_row(-21846, 21845, 21845);
    directed_rows[6]  = sample_row(1, -1, 1);
    directed_rows[7]  = sample_row(410, 0, 5120);
    directed_rows[8]  = sample_row(411, 0, 5121);
    directed_rows[9]  = sample_row(0, -32768, -32767);
    directed_rows[10] = sample_row(32767, 32767, 32767);
    directed_rows[11] = sample_row(-32768, -32768, 0);
    directed_rows[11].typed = 1'b1;
    // Enabled frame: full-scale change at joints 2 and 5 (tie keeps joint 2)
    for (int i = 12; i < DIRECTED_LEN; i++) directed_rows[i] = sample_row(0, 0, 0);
    directed_rows[12].enable_first = 1'b1;
    directed_rows[14] = sample_row(32767, -32768, 0);
    directed_rows[15] = sample_row(0, 0, -32768);
    directed_rows[17] = sample_row(-32768, 32767, 0);
    directed_rows[19] = sample_row(0, 0, 32767);
    directed_rows[23].typed                    = 1'b1;
    directed_rows[23].want.violation           = VIOL_TARGET_RATE;
    directed_rows[23].want.detail              = 4'd2;
    directed_rows[23].want.peak_target_rate    = 22'd204796;
    directed_rows[23].want.peak_feedback_speed = 16'd32768;
    directed_rows[23].want.total_change        = 20'd131070;
    directed_rows[23].want.big_change_count    = 4'd2;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    for (int i = 0; i < DIRECTED_LEN; i++) begin
      if (directed_rows[i].enable_first) begin
        settle_block();
        s = live_cfg;
        s.check_enable = 1'b1;
        apply_settings(s);
      end
      send_sample(directed_rows[i].new_target, directed_rows[i].old_target,
                  directed_rows[i].joint_speed, directed_rows[i].typed,
                  directed_rows[i].want);
    end

    // Random phases: new settings and idling style per phase, whole frames only
    for (int phase = 0; phase < PHASES; phase++) begin
      settle_block();
      case (phase)
        0: begin
          s.check_enable = 1'b1; s.enforce_mask = 3'd7; s.policy_rate_hz = 10'd1000;
          s.target_rate_limit = 22'd4194303; s.feedback_speed_limit = 16'd32768;
          s.significant_change = 16'd65535; s.aggregate_change_limit = 20'd1048575;
        end
        1: begin
          s.check_enable = 1'b1; s.enforce_mask = 3'd6; s.policy_rate_hz = 10'd1;
          s.target_rate_limit = 22'd1; s.feedback_speed_limit = 16'd1;
          s.significant_change = 16'd1; s.aggregate_change_limit = 20'd1;
        end
        2: begin
          s.check_enable = 1'b1; s.enforce_mask = 3'd7; s.policy_rate_hz = '0;
          s.target_rate_limit = '0; s.feedback_speed_limit = '0;
          s.significant_change = '0; s.aggregate_change_limit = '0;
        end
        default: begin
          s.check_enable           = (phase != 3) && ($urandom_range(0, 5) != 0);
          s.enforce_mask           = 3'($urandom);
          s.policy_rate_hz         = 10'($urandom_range(0, 1023));
          s.target_rate_limit      = RATE_W'(span_rand(RATE_W));
          s.feedback_speed_limit   = SPEED_W'(span_rand(SPEED_W));
          s.significant_change     = CHANGE_W'(span_rand(CHANGE_W));
          s.aggregate_change_limit = SUM_W'(span_rand(SUM_W));
        end
      endcase
      apply_settings(s);

      case (phase % 4)
        0:       begin source_gap_pct = 0;  sink_stall_pct = 0;  end
        1:       begin source_gap_pct = 47; sink_stall_pct = 0;  end
        2:       begin source_gap_pct = 0;  sink_stall_pct = 47; end
        default: begin source_gap_pct = 18; sink_stall_pct = 18; end
      endcase
      // Hold the result side off so the block backs up and stalls its input
      if (phase == 4) hold_request = 1'b1;

      for (int frame = 0; frame < FRAMES_EACH; frame++) begin
        style = $urandom_range(0, 3);
        for (int j = 0; j < JOINTS; j++) begin
          ot = ANGLE_W'($urandom);
          case (style)
            0: begin
              nt = ANGLE_W'(int'(ot) + int'($urandom_range(0, 64)) - 32);
              sp = SPEED_W'(int'($urandom_range(0, 256)) - 128);
            end
            1: begin
              nt = ANGLE_W'(int'(ot) + int'($urandom_range(0, 2048)) - 1024);
              sp = SPEED_W'(int'($urandom_range(0, 8192)) - 4096);
            end
            default: begin
              nt = ANGLE_W'($urandom);
              sp = SPEED_W'($urandom);
            end
          endcase
          if ($urandom_range(0, 31) == 0) sp = SPEED_W'(-32768);
          send_sample(nt, ot, sp, 1'b0, '0);
        end
      end
    end

    settle_block();
    if (mismatches == 0)
      $display("joint_motion_safety_check_top_tb: done, clean");
    else
      $display("joint_motion_safety_check_top_tb: done, errors");
    $finish;
  end

endmodule
